@@ hdl/z_clipped_quadric_hit_core_defines.svh @@
// Assertion macros shared by the z clipped quadric hit core.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef Z_CLIPPED_QUADRIC_HIT_CORE_DEFINES_SVH
`define Z_CLIPPED_QUADRIC_HIT_CORE_DEFINES_SVH

// same-cycle implication
`define ZCQH_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZCQH_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/zcqh_pkg.sv @@
// Types and constants of the z clipped quadric hit core.
// No dependencies.
package zcqh_pkg;

  typedef enum logic [1:0] {
    MODE_BELOW   = 2'd0,
    MODE_ABOVE   = 2'd1,
    MODE_BETWEEN = 2'd2
  } clip_mode_e;

  localparam logic signed [31:0] NO_HIT_DIST = 32'hFFFF0000;
  localparam int SQRT_STAGES = 24;
  localparam int DIV_STAGES  = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] delta;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_z;
    logic signed [31:0] upper_bound;
    logic signed [31:0] lower_bound;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
  } out_t;

  // per-item context that rides along both halves
  typedef struct packed {
    logic               nohit;
    logic [1:0]         mode;
    logic signed [31:0] oz;
    logic signed [31:0] dz;
    logic signed [31:0] up;
    logic signed [31:0] lo;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [23:0]        s;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ hdl/z_clipped_quadric_hit_core.sv @@
// Top level of the z clipped quadric hit core: front, queue and back halves.
// Depends on zcqh_pkg, zcqh_front, zcqh_fifo and zcqh_back.
//
//   channel   handshake           payload
//   input     start / busy        in_i     (zcqh_pkg::in_t)
//   result    done_o (strobe)     result_o (zcqh_pkg::out_t)
//
// One item accepted per cycle while busy is low.
// The path runs through the 24-stage square root and the 32-stage root dividers.
// Reset is asynchronous, active low, and clears only the valid and queue state.
// busy follows a full queue; the back half pops one entry each non-empty cycle.
// The result side has no stall: each result is shown for one cycle only.
module z_clipped_quadric_hit_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  zcqh_pkg::in_t  in_i,
  output logic           done_o,
  output zcqh_pkg::out_t result_o
);
  import zcqh_pkg::*;

  logic       fr_vld;
  item_t      fr_item, q_item;
  fifo_stat_t q_stat;

  assign busy = q_stat.full;

  zcqh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start && !busy),
    .in_i        (in_i),
    .out_valid_o (fr_vld),
    .out_o       (fr_item)
  );

  zcqh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_vld),
    .push_data_i (fr_item),
    .pop_i       (1'b1),
    .pop_data_o  (q_item),
    .stat_o      (q_stat)
  );

  zcqh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_stat.empty),
    .in_i        (q_item),
    .out_valid_o (done_o),
    .out_o       (result_o)
  );

endmodule

@@ hdl/zcqh_front.sv @@
// Front half: accepts items, flags the no-hit cases and takes sqrt(delta*2^16).
// Depends on zcqh_pkg.
module zcqh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  zcqh_pkg::in_t  in_i,
  output logic           out_valid_o,
  output zcqh_pkg::item_t out_o
);
  import zcqh_pkg::*;

  typedef struct packed {
    item_t       it;
    logic [47:0] rad;
    logic [25:0] rem;
    logic [23:0] root;
  } sq_t;

  logic [SQRT_STAGES:0] vld_q;
  sq_t                  sq_q [SQRT_STAGES+1];
  sq_t                  sq_d [SQRT_STAGES+1];

  always_comb begin
    sq_d[0].it.ctx.nohit = (in_i.cmd > MODE_BETWEEN) || in_i.delta[31] ||
                           (in_i.coef_a == '0);
    sq_d[0].it.ctx.mode  = in_i.cmd;
    sq_d[0].it.ctx.oz    = in_i.origin_z;
    sq_d[0].it.ctx.dz    = in_i.dir_z;
    sq_d[0].it.ctx.up    = in_i.upper_bound;
    sq_d[0].it.ctx.lo    = in_i.lower_bound;
    sq_d[0].it.a         = in_i.coef_a;
    sq_d[0].it.b         = in_i.coef_b;
    sq_d[0].it.s         = '0;
    sq_d[0].rad          = {1'b0, in_i.delta[30:0], 16'h0000};
    sq_d[0].rem          = '0;
    sq_d[0].root         = '0;
  end

  // one result bit per stage, two radicand bits consumed each
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    logic [27:0] t;
    logic [27:0] trial;
    always_comb begin
      t     = {sq_q[i].rem, sq_q[i].rad[47-2*i -: 2]};
      trial = {2'b00, sq_q[i].root, 2'b01};
      sq_d[i+1] = sq_q[i];
      if (t >= trial) begin
        sq_d[i+1].rem  = 26'(t - trial);
        sq_d[i+1].root = {sq_q[i].root[22:0], 1'b1};
      end else begin
        sq_d[i+1].rem  = t[25:0];
        sq_d[i+1].root = {sq_q[i].root[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_STAGES-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= SQRT_STAGES; j++) begin
      sq_q[j] <= sq_d[j];
    end
  end

  always_comb begin
    out_o   = sq_q[SQRT_STAGES].it;
    out_o.s = sq_q[SQRT_STAGES].root;
  end
  assign out_valid_o = vld_q[SQRT_STAGES];

endmodule

@@ hdl/zcqh_fifo.sv @@
// Short register queue between the front and back halves.
// Depends on zcqh_pkg and the assertion macro header.
`include "z_clipped_quadric_hit_core_defines.svh"
module zcqh_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  zcqh_pkg::item_t      push_data_i,
  input  logic                 pop_i,
  output zcqh_pkg::item_t      pop_data_o,
  output zcqh_pkg::fifo_stat_t stat_o
);
  import zcqh_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];

  `ZCQH_ASSERT_IMP(a_no_drop, push_i, !stat_o.full, "transfer into full queue")
  `ZCQH_ASSERT_NXT(a_cnt_inc, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "count slip")
  `ZCQH_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "count overrun")

endmodule

@@ hdl/zcqh_back.sv @@
// Back half: both root divisions, saturation, hit heights and root choice.
// Depends on zcqh_pkg and the assertion macro header.
`include "z_clipped_quadric_hit_core_defines.svh"
module zcqh_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  zcqh_pkg::item_t in_i,
  output logic            out_valid_o,
  output zcqh_pkg::out_t  out_o
);
  import zcqh_pkg::*;

  typedef struct packed {
    ctx_t        ctx;
    logic        ovf1, ovf2, neg1, neg2;
    logic [15:0] nlo1, nlo2;
    logic [32:0] dmag;
    logic [32:0] rem1, rem2;
    logic [31:0] q1, q2;
  } div_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] q;
  } step_t;

  function automatic step_t div_step(logic [32:0] rem, logic nb, logic [32:0] d,
                                     logic [31:0] q);
    logic [33:0] t;
    step_t       r;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      r.rem = 33'(t - {1'b0, d});
      r.q   = {q[30:0], 1'b1};
    end else begin
      r.rem = t[32:0];
      r.q   = {q[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_root(logic ovf, logic neg, logic [31:0] q);
    logic signed [31:0] r;
    if (!neg) begin
      r = (ovf || q[31]) ? 32'sh7FFFFFFF : signed'(q);
    end else begin
      r = (ovf || q > 32'h80000000) ? 32'sh80000000 : signed'(-q);
    end
    return r;
  endfunction

  function automatic logic in_clip(logic [1:0] m, logic signed [63:0] h,
                                   logic signed [63:0] u, logic signed [63:0] l);
    logic r;
    unique case (clip_mode_e'(m))
      MODE_BELOW:   r = h < u;
      MODE_ABOVE:   r = h > u;
      MODE_BETWEEN: r = (h < u) && (h > l);
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic out_clip(logic [1:0] m, logic signed [63:0] h,
                                    logic signed [63:0] u, logic signed [63:0] l);
    logic r;
    unique case (clip_mode_e'(m))
      MODE_BELOW:   r = h > u;
      MODE_ABOVE:   r = h < u;
      MODE_BETWEEN: r = (h > u) || (h < l);
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  // entry stage: numerators -b -/+ s and denominator 2a as sign and magnitude
  logic signed [33:0] num1, num2, den;
  logic [33:0]        mag1, mag2, dmg;
  div_t               ent_d;

  always_comb begin
    num1 = -34'(in_i.b) - 34'(signed'({1'b0, in_i.s}));
    num2 = -34'(in_i.b) + 34'(signed'({1'b0, in_i.s}));
    den  = 34'(in_i.a) <<< 1;
    mag1 = num1[33] ? 34'(-num1) : 34'(num1);
    mag2 = num2[33] ? 34'(-num2) : 34'(num2);
    dmg  = den[33] ? 34'(-den) : 34'(den);
    ent_d.ctx  = in_i.ctx;
    ent_d.neg1 = num1[33] ^ den[33];
    ent_d.neg2 = num2[33] ^ den[33];
    ent_d.dmag = dmg[32:0];
    ent_d.nlo1 = mag1[15:0];
    ent_d.nlo2 = mag2[15:0];
    // quotient of 2^32 or more saturates whatever its sign
    ent_d.ovf1 = {17'h0, mag1[31:16]} >= dmg[32:0];
    ent_d.ovf2 = {17'h0, mag2[31:16]} >= dmg[32:0];
    ent_d.rem1 = {17'h0, mag1[31:16]};
    ent_d.rem2 = {17'h0, mag2[31:16]};
    ent_d.q1   = '0;
    ent_d.q2   = '0;
  end

  logic [DIV_STAGES:0] dvld_q;
  div_t                dv_q [DIV_STAGES+1];
  div_t                dv_d [DIV_STAGES+1];

  assign dv_d[0] = ent_d;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic  b1, b2;
    step_t s1, s2;
    always_comb begin
      b1 = (i < 16) ? dv_q[i].nlo1[4'(15 - i)] : 1'b0;
      b2 = (i < 16) ? dv_q[i].nlo2[4'(15 - i)] : 1'b0;
      s1 = div_step(dv_q[i].rem1, b1, dv_q[i].dmag, dv_q[i].q1);
      s2 = div_step(dv_q[i].rem2, b2, dv_q[i].dmag, dv_q[i].q2);
      dv_d[i+1]      = dv_q[i];
      dv_d[i+1].rem1 = s1.rem;
      dv_d[i+1].q1   = s1.q;
      dv_d[i+1].rem2 = s2.rem;
      dv_d[i+1].q2   = s2.q;
    end
  end

  // saturate, multiply, add, choose
  ctx_t               sat_ctx_q, mul_ctx_q, hgt_ctx_q;
  logic signed [31:0] k1_q, k2_q, mk1_q, mk2_q, hk1_q, hk2_q;
  logic signed [63:0] p1_q, p2_q, h1_q, h2_q;
  logic               sat_vld_q, mul_vld_q, hgt_vld_q, out_vld_q;
  out_t               out_q, out_d;

  logic signed [63:0] oz64, up64, lo64;
  logic               pick1, pick2;

  assign oz64 = {{16{mul_ctx_q.oz[31]}}, mul_ctx_q.oz, 16'h0000};
  assign up64 = {{16{hgt_ctx_q.up[31]}}, hgt_ctx_q.up, 16'h0000};
  assign lo64 = {{16{hgt_ctx_q.lo[31]}}, hgt_ctx_q.lo, 16'h0000};

  always_comb begin
    pick1 = (hk1_q > 0) && in_clip(hgt_ctx_q.mode, h1_q, up64, lo64) &&
            (((hk2_q > 0) && (hk1_q < hk2_q)) ||
             ((hk1_q > hk2_q) && out_clip(hgt_ctx_q.mode, h2_q, up64, lo64)));
    pick2 = (hk2_q > 0) && in_clip(hgt_ctx_q.mode, h2_q, up64, lo64) &&
            (((hk1_q > 0) && (hk2_q < hk1_q)) ||
             ((hk2_q > hk1_q) && out_clip(hgt_ctx_q.mode, h1_q, up64, lo64)));
    out_d.hit      = 1'b0;
    out_d.distance = NO_HIT_DIST;
    if (!hgt_ctx_q.nohit) begin
      if (pick1) begin
        out_d.hit      = 1'b1;
        out_d.distance = hk1_q;
      end else if (pick2) begin
        out_d.hit      = 1'b1;
        out_d.distance = hk2_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q    <= '0;
      sat_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      hgt_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      dvld_q    <= {dvld_q[DIV_STAGES-1:0], in_valid_i};
      sat_vld_q <= dvld_q[DIV_STAGES];
      mul_vld_q <= sat_vld_q;
      hgt_vld_q <= mul_vld_q;
      out_vld_q <= hgt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= DIV_STAGES; j++) begin
      dv_q[j] <= dv_d[j];
    end
    sat_ctx_q <= dv_q[DIV_STAGES].ctx;
    k1_q      <= sat_root(dv_q[DIV_STAGES].ovf1, dv_q[DIV_STAGES].neg1, dv_q[DIV_STAGES].q1);
    k2_q      <= sat_root(dv_q[DIV_STAGES].ovf2, dv_q[DIV_STAGES].neg2, dv_q[DIV_STAGES].q2);
    mul_ctx_q <= sat_ctx_q;
    mk1_q     <= k1_q;
    mk2_q     <= k2_q;
    p1_q      <= k1_q * sat_ctx_q.dz;
    p2_q      <= k2_q * sat_ctx_q.dz;
    hgt_ctx_q <= mul_ctx_q;
    hk1_q     <= mk1_q;
    hk2_q     <= mk2_q;
    h1_q      <= oz64 + p1_q;
    h2_q      <= oz64 + p2_q;
    out_q     <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `ZCQH_ASSERT_IMP(a_miss_dist, out_vld_q && !out_q.hit, out_q.distance == NO_HIT_DIST,
                   "miss without -1.0 distance")
  `ZCQH_ASSERT_NXT(a_flagged_miss, hgt_vld_q && hgt_ctx_q.nohit, !out_q.hit,
                   "flagged item reported a hit")

endmodule
